@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the packer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/core/f2b_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// f2b_pkg
// Types, character constants and base coding for the FASTA 2-bit packer.
// ---------------------------------------------------------------------------
package f2b_pkg;

   typedef enum logic [1:0] {
      PH_START  = 2'd0,
      PH_HEADER = 2'd1,
      PH_BODY   = 2'd2,
      PH_HALT   = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      ST_DATA       = 3'd0,
      ST_FLUSH_DONE = 3'd1,
      ST_DONE_EMPTY = 3'd2,
      ST_NO_START   = 3'd3,
      ST_EOF_HEADER = 3'd4,
      ST_HDR_LONG   = 3'd5
   } status_type;

   localparam logic [7:0] CH_GT = 8'h3E;
   localparam logic [7:0] CH_C  = 8'h43;
   localparam logic [7:0] CH_G  = 8'h47;
   localparam logic [7:0] CH_T  = 8'h54;
   localparam logic [7:0] CH_U  = 8'h55;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_CR = 8'h0D;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      status_type status;
   } f2b_rsp_type;

   function automatic logic [1:0] base_code(input logic [7:0] ch);
      logic [1:0] code;
      unique case (ch)
         CH_C:       code = 2'd1;
         CH_G:       code = 2'd2;
         CH_T, CH_U: code = 2'd3;
         default:    code = 2'd0;
      endcase
      return code;
   endfunction

endpackage

@@ rtl/core/fasta_to_2bit_packer.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fasta_to_2bit_packer
// FASTA text to packed 2-bit nucleotide bytes, one beat per cycle while ready.
// ---------------------------------------------------------------------------
// Path: each result is registered in the output register, via skid on a stall.
// Throughput: one req beat per cycle; the output register and one skid entry
//   absorb rsp stalls, and req_tready drops only while the skid entry is full.
// Reset: synchronous, active high; parser returns to waiting for '>', both
//   output entries are emptied. After any done or error status the block
//   drops all further beats until the next reset.
`include "assert_macros.svh"
module fasta_to_2bit_packer
   import f2b_pkg::*;
#(
   parameter int MAX_HEADER = 1024
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // at_end: end of file, tdata ignored
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [2:0] rsp_tuser    // [2:0] status
);

   // Header counter holds 0..MAX_HEADER.
   localparam int HDR_W = $clog2(MAX_HEADER + 1);

   phase_type        phase_ff, phase_in;
   logic [HDR_W-1:0] header_count_ff, header_count_in;
   logic [5:0]       packed_bits_ff, packed_bits_in;
   logic [1:0]       slot_ff, slot_in;

   phase_type        phase_nx;
   logic [HDR_W-1:0] header_count_nx;
   logic [5:0]       packed_bits_nx;
   logic [1:0]       slot_nx;
   f2b_rsp_type      step_rsp;
   logic             req_accept;
   logic             push;

   assign req_accept = req_tvalid && req_tready;

   // Decode one character against the current parser state.
   f2b_step #(
      .MAX_HEADER (MAX_HEADER),
      .HDR_W      (HDR_W)
   ) u_step (
      .phase           (phase_ff),
      .header_count    (header_count_ff),
      .packed_bits     (packed_bits_ff),
      .slot            (slot_ff),
      .in_byte         (req_tdata),
      .at_end          (req_tlast),
      .phase_nx        (phase_nx),
      .header_count_nx (header_count_nx),
      .packed_bits_nx  (packed_bits_nx),
      .slot_nx         (slot_nx),
      .rsp             (step_rsp)
   );

   // Advance the parser only on an accepted beat; hold otherwise.
   always_comb begin
      phase_in        = phase_ff;
      header_count_in = header_count_ff;
      packed_bits_in  = packed_bits_ff;
      slot_in         = slot_ff;
      if (req_accept) begin
         phase_in        = phase_nx;
         header_count_in = header_count_nx;
         packed_bits_in  = packed_bits_nx;
         slot_in         = slot_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_START;
         header_count_ff <= '0;
         packed_bits_ff  <= '0;
         slot_ff         <= '0;
      end else begin
         phase_ff        <= phase_in;
         header_count_ff <= header_count_in;
         packed_bits_ff  <= packed_bits_in;
         slot_ff         <= slot_in;
      end
   end

   assign push = req_accept && step_rsp.valid;

   // Result register with skid entry; it sets req_tready.
   f2b_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_rsp   (step_rsp),
      .in_ready   (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   `ASSERT_NEXT(a_halt_sticks, clock, reset, phase_ff == PH_HALT, phase_ff == PH_HALT)
   `ASSERT_IMPL(a_halt_silent, clock, reset, phase_ff == PH_HALT, !step_rsp.valid)
   `ASSERT_NEXT(a_result_halts, clock, reset,
      push && (step_rsp.status != ST_DATA), phase_ff == PH_HALT)

endmodule

@@ rtl/core/f2b_step.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// f2b_step
// Per-byte decode: next parser state and the optional result for one beat.
// ---------------------------------------------------------------------------
module f2b_step
   import f2b_pkg::*;
#(
   parameter int MAX_HEADER = 1024,
   parameter int HDR_W      = 11
) (
   input  phase_type   phase,
   input  logic [HDR_W-1:0] header_count,
   input  logic [5:0]  packed_bits,
   input  logic [1:0]  slot,
   input  logic [7:0]  in_byte,
   input  logic        at_end,
   output phase_type   phase_nx,
   output logic [HDR_W-1:0] header_count_nx,
   output logic [5:0]  packed_bits_nx,
   output logic [1:0]  slot_nx,
   output f2b_rsp_type rsp
);

   logic       is_eol;
   logic [1:0] code;

   assign is_eol = (in_byte == CH_LF) || (in_byte == CH_CR);
   assign code   = base_code(in_byte);

   always_comb begin
      phase_nx        = phase;
      header_count_nx = header_count;
      packed_bits_nx  = packed_bits;
      slot_nx         = slot;
      rsp.valid       = 1'b0;
      rsp.data        = 8'd0;
      rsp.status      = ST_DATA;
      unique case (phase)
         PH_START: begin
            if (at_end || (in_byte != CH_GT)) begin
               phase_nx   = PH_HALT;
               rsp.valid  = 1'b1;
               rsp.status = ST_NO_START;
            end else begin
               phase_nx        = PH_HEADER;
               header_count_nx = '0;
            end
         end
         PH_HEADER: begin
            priority if (at_end) begin
               phase_nx   = PH_HALT;
               rsp.valid  = 1'b1;
               rsp.status = ST_EOF_HEADER;
            end else if (is_eol) begin
               phase_nx       = PH_BODY;
               packed_bits_nx = '0;
               slot_nx        = '0;
            end else if (header_count >= HDR_W'(MAX_HEADER)) begin
               phase_nx   = PH_HALT;
               rsp.valid  = 1'b1;
               rsp.status = ST_HDR_LONG;
            end else begin
               header_count_nx = header_count + HDR_W'(1);
            end
         end
         PH_BODY: begin
            priority if (at_end) begin
               phase_nx  = PH_HALT;
               rsp.valid = 1'b1;
               if (slot != 2'd0) begin
                  rsp.data   = {2'b00, packed_bits};
                  rsp.status = ST_FLUSH_DONE;
               end else begin
                  rsp.status = ST_DONE_EMPTY;
               end
            end else if (is_eol) begin
               // skip line breaks inside the sequence
            end else begin
               slot_nx = slot + 2'd1;
               unique case (slot)
                  2'd0: packed_bits_nx = {4'b0000, code};
                  2'd1: packed_bits_nx = {2'b00, code, packed_bits[1:0]};
                  2'd2: packed_bits_nx = {code, packed_bits[3:0]};
                  2'd3: begin
                     packed_bits_nx = '0;
                     rsp.valid      = 1'b1;
                     rsp.data       = {code, packed_bits};
                     rsp.status     = ST_DATA;
                  end
                  default: packed_bits_nx = packed_bits;
               endcase
            end
         end
         PH_HALT: begin
            // drop everything until reset
         end
         default: phase_nx = PH_HALT;
      endcase
   end

endmodule

@@ rtl/core/f2b_skid.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// f2b_skid
// Output register plus one skid entry between the parser and the rsp bus.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module f2b_skid
   import f2b_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  f2b_rsp_type push_rsp,
   output logic        in_ready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   output logic [2:0]  rsp_tuser
);

   logic        out_valid_ff, out_valid_in;
   logic        skid_valid_ff, skid_valid_in;
   f2b_rsp_type out_ff, out_in;
   f2b_rsp_type skid_ff, skid_in;
   logic        drain;

   assign drain    = out_valid_ff && rsp_tready;
   assign in_ready = !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (drain) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || drain) begin
            out_in       = push_rsp;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = push_rsp;
            skid_valid_in = 1'b1;
         end
      end else if (drain) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff.data;
   assign rsp_tuser  = out_ff.status;

   `ASSERT_IMPL(a_skid_needs_out, clock, reset, skid_valid_ff, out_valid_ff)
   `ASSERT_NEXT(a_stall_fills_skid, clock, reset,
      push && out_valid_ff && !rsp_tready && !skid_valid_ff, skid_valid_ff)
   `ASSERT_NEXT(a_push_shows, clock, reset, push && in_ready, out_valid_ff)

endmodule

@@ tb/sv/fasta_to_2bit_packer_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fasta_to_2bit_packer_tb
// Self-checking bench for the FASTA 2-bit packer: one FASTA file is streamed
// in after the single reset, and each packed byte or status is checked
// against a cycle-free software parse of the same stream.
// ---------------------------------------------------------------------------
module fasta_to_2bit_packer_tb
   import f2b_pkg::*;
();

   localparam int HDR_LIMIT = 1024;      // header characters allowed before CR/LF
   localparam int HDR_FILL = 24;         // header characters in the stimulus
   localparam int BODY_BEATS = 1000;     // body characters, directed and random
   localparam logic [7:0] CH_A = 8'h41;

   // One character beat as the sender presents it. hold_drain asks the
   // sender to wait until every expected result has arrived before sending.
   typedef struct {
      logic [7:0] ch;
      logic       eof;
      bit         hold_drain;
   } char_beat_type;

   // One packed byte with its status, as the block should return it.
   typedef struct {
      logic [7:0] data;
      status_type status;
   } packed_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] in_byte
   logic       req_tlast = 1'b0;    // at_end
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] out_byte
   logic [2:0] rsp_tuser;           // [2:0] status

   char_beat_type     char_q[$];      // beats not yet presented
   packed_result_type expected_q[$];  // predicted results not yet returned
   int                total_beats = 0;
   int                beats_sent = 0;
   int                beats_accepted = 0;
   int                mismatch_count = 0;
   bit                drain_armed = 1'b0;

   // Parser state of the predictor, mirroring what the block keeps.
   phase_type   parse_phase = PH_START;
   int unsigned hdr_seen = 0;
   logic [7:0]  pack_acc = 8'h00;
   logic [1:0]  pack_slot = 2'd0;

   fasta_to_2bit_packer #(
      .MAX_HEADER(HDR_LIMIT)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   // Advance the parse by one accepted character beat and queue the result
   // it should produce, if any.
   function automatic void predict_beat(input logic [7:0] ch, input logic eof);
      logic       line_break;
      logic [1:0] code;
      line_break = (ch == CH_LF) || (ch == CH_CR);
      case (ch)
         CH_C:       code = 2'd1;
         CH_G:       code = 2'd2;
         CH_T, CH_U: code = 2'd3;
         default:    code = 2'd0;
      endcase
      case (parse_phase)
         PH_START: begin
            // Anything but '>' as the first beat, end of file included, is fatal.
            if (eof || ch != CH_GT) begin
               parse_phase = PH_HALT;
               expected_q.push_back('{8'h00, ST_NO_START});
            end else begin
               parse_phase = PH_HEADER;
               hdr_seen = 0;
            end
         end
         PH_HEADER: begin
            if (eof) begin
               parse_phase = PH_HALT;
               expected_q.push_back('{8'h00, ST_EOF_HEADER});
            end else if (line_break) begin
               // Only the first break ends the header; later ones are body breaks.
               parse_phase = PH_BODY;
               pack_acc = 8'h00;
               pack_slot = 2'd0;
            end else if (hdr_seen >= HDR_LIMIT) begin
               parse_phase = PH_HALT;
               expected_q.push_back('{8'h00, ST_HDR_LONG});
            end else begin
               hdr_seen++;
            end
         end
         PH_BODY: begin
            if (eof) begin
               parse_phase = PH_HALT;
               if (pack_slot != 2'd0)
                  expected_q.push_back('{pack_acc, ST_FLUSH_DONE});
               else
                  expected_q.push_back('{8'h00, ST_DONE_EMPTY});
            end else if (!line_break) begin
               pack_acc[pack_slot*2 +: 2] = code;
               pack_slot = pack_slot + 2'd1;
               if (pack_slot == 2'd0) begin
                  expected_q.push_back('{pack_acc, ST_DATA});
                  pack_acc = 8'h00;
               end
            end
         end
         default: ;   // halted: drop everything until reset
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic add_beat(input logic [7:0] ch, input logic eof, input bit hold_drain);
      char_beat_type beat;
      beat.ch = ch;
      beat.eof = eof;
      beat.hold_drain = hold_drain;
      char_q.push_back(beat);
   endtask

   // Driver: present the next pending beat whenever the channel is free,
   // with random idle cycles on both sides that depend on how far the
   // stream has progressed.
   always @(posedge clock) begin
      int            stage;
      int            send_idle;
      int            recv_idle;
      bit            go;
      char_beat_type beat;
      stage = (total_beats == 0) ? 0 : (beats_sent * 3) / total_beats;
      // First third: sender 38 / receiver 52, then swapped, then no idling.
      send_idle = (stage == 0) ? 38 : (stage == 1) ? 52 : 0;
      recv_idle = (stage == 0) ? 52 : (stage == 1) ? 38 : 0;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'h00;
         req_tlast  <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle);
         // Hold the current beat until it is taken.
         if (!req_tvalid || req_tready) begin
            go = (char_q.size() != 0) && ($urandom_range(0, 99) >= send_idle);
            if (go && char_q[0].hold_drain) begin
               // Arm on the first look so the beat taken at this edge is
               // already predicted when the queue is checked for emptiness.
               if (drain_armed && expected_q.size() == 0) begin
                  char_q[0].hold_drain = 1'b0;
               end else begin
                  drain_armed = 1'b1;
                  go = 1'b0;
               end
            end
            if (go) begin
               beat = char_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= beat.ch;
               req_tlast  <= beat.eof;
               beats_sent++;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check returned beats against the oldest expectation, then
   // predict from the character beat taken at the same edge. A result is
   // registered before it reaches rsp, so this order is safe.
   always @(posedge clock) begin
      packed_result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               report_mismatch($sformatf("unexpected beat data=%h status=%0d",
                                         rsp_tdata, rsp_tuser));
            end else begin
               want = expected_q.pop_front();
               if (rsp_tdata !== want.data)
                  report_mismatch($sformatf("data %h, expected %h (status %0d)",
                                            rsp_tdata, want.data, want.status));
               if (rsp_tuser !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_tuser, want.status));
            end
         end
         if (req_tvalid && req_tready) begin
            predict_beat(req_tdata, req_tlast);
            beats_accepted++;
         end
      end
   end

   // Stimulus: one FASTA file, since the block halts for good once it
   // reports completion and reset is applied only once.
   initial begin
      string      hdr_text;
      string      body_text;
      logic [7:0] ch;
      int         pick;
      hdr_text  = ">";
      body_text = "ACGTUacgtuN-";

      // Header start, then byte extremes and a stray '>' inside the header.
      add_beat(CH_GT, 1'b0, 1'b0);
      add_beat(8'h00, 1'b0, 1'b0);
      add_beat(8'hFF, 1'b0, 1'b0);
      add_beat(8'h7F, 1'b0, 1'b0);
      add_beat(8'h80, 1'b0, 1'b0);
      add_beat(hdr_text[0], 1'b0, 1'b0);
      // Pad the header with random characters, well under the limit.
      for (int i = 5; i < HDR_FILL; i++) begin
         ch = 8'($urandom_range(0, 255));
         if (ch == CH_LF || ch == CH_CR)
            ch = ch ^ 8'h40;
         add_beat(ch, 1'b0, 1'b0);
      end
      // CR ends the header; the LF after it is a plain body break.
      add_beat(CH_CR, 1'b0, 1'b0);
      add_beat(CH_LF, 1'b0, 1'b0);

      // Directed body: every base letter, lowercase and ambiguity codes,
      // byte extremes and line breaks of both kinds.
      for (int i = 0; i < body_text.len(); i++)
         add_beat(body_text[i], 1'b0, 1'b0);
      add_beat(8'h00, 1'b0, 1'b0);
      add_beat(8'hFF, 1'b0, 1'b0);
      add_beat(CH_CR, 1'b0, 1'b0);
      add_beat(CH_LF, 1'b0, 1'b0);
      add_beat(CH_LF, 1'b0, 1'b0);
      add_beat(CH_CR, 1'b0, 1'b0);

      // Random body: mostly sequence letters, some breaks, some arbitrary bytes.
      for (int i = 18; i < BODY_BEATS; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            case ($urandom_range(0, 4))
               0:       ch = CH_A;
               1:       ch = CH_C;
               2:       ch = CH_G;
               3:       ch = CH_T;
               default: ch = CH_U;
            endcase
         end else if (pick < 75) begin
            ch = $urandom_range(0, 1) ? CH_LF : CH_CR;
         end else begin
            ch = 8'($urandom_range(0, 255));
         end
         // Midway, hold the stream until the block has returned everything.
         add_beat(ch, 1'b0, i == BODY_BEATS / 2);
      end

      // End of file with random data; the flush depends on the random fill.
      add_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0);

      // After completion the block must drop every beat, even a new header.
      add_beat(CH_GT, 1'b0, 1'b0);
      for (int i = 0; i < 10; i++)
         add_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
      add_beat(CH_A, 1'b1, 1'b0);

      total_beats = char_q.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (beats_accepted != total_beats)
         @(posedge clock);
      while (expected_q.size() != 0)
         @(posedge clock);
      // Allow for a late, unwanted beat from a dropped character.
      repeat (8) @(posedge clock);

      if (mismatch_count == 0)
         $display("fasta_to_2bit_packer_tb: PASS");
      else
         $display("fasta_to_2bit_packer_tb: FAIL");
      $finish;
   end

   // Watchdog: about 1040 beats, far below this timeout even with heavy stalls.
   initial begin
      #2_000_000;
      $display("fasta_to_2bit_packer_tb: FAIL");
      $finish;
   end

endmodule

@@ fasta_to_2bit_packer.f @@
+incdir+rtl/core
rtl/core/f2b_pkg.sv
rtl/core/f2b_step.sv
rtl/core/f2b_skid.sv
rtl/core/fasta_to_2bit_packer.sv
tb/sv/fasta_to_2bit_packer_tb.sv
